[design/ivf_pkg.sv]
// ----------------------------------------------------------------------------
// ivf_pkg
// Types and constants shared by the inverse-variance fusion block.
// ----------------------------------------------------------------------------
`default_nettype none
package ivf_pkg;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_EMPTY    = 2'd1;
  localparam logic [1:0] STATUS_ZERO_SIG = 2'd2;
  localparam logic [1:0] STATUS_OVERFLOW = 2'd3;

  // Divider request: 128-bit numerator over 64-bit divisor.
  typedef struct packed {
    logic [127:0] num;
    logic [63:0]  den;
  } div_req_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_WDIV,
    ST_WSUM,
    ST_MULLO,
    ST_MULHI,
    ST_MSUM,
    ST_MDIV,
    ST_SDIV,
    ST_SQRT,
    ST_OUT
  } state_t;

endpackage
`default_nettype wire

[design/ivf_if.sv]
// ----------------------------------------------------------------------------
// ivf_in_if / ivf_out_if
// Valid/ready channels carrying estimates in and fused results out.
// ----------------------------------------------------------------------------
`default_nettype none
interface ivf_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] est_mean;
  logic        [31:0] est_sigma;
  logic               invalid_flag;
  logic               unreliable_flag;
  logic               last_item;
  modport source (output valid, est_mean, est_sigma, invalid_flag, unreliable_flag,
                  last_item, input ready);
  modport sink (input valid, est_mean, est_sigma, invalid_flag, unreliable_flag,
                last_item, output ready);
endinterface

interface ivf_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] fused_mean;
  logic        [31:0] fused_sigma;
  logic        [8:0]  used_count;
  logic        [1:0]  status;
  modport source (output valid, fused_mean, fused_sigma, used_count, status,
                  input ready);
  modport sink (input valid, fused_mean, fused_sigma, used_count, status,
                output ready);
endinterface
`default_nettype wire

[design/ivf_div.sv]
// ----------------------------------------------------------------------------
// ivf_div
// Restoring divider, one quotient bit per cycle, 128-bit quotient.
// ----------------------------------------------------------------------------
`default_nettype none
module ivf_div (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire ivf_pkg::div_req_t req,
  output logic                  done,
  output logic [127:0]          quot
);
  logic [127:0] num;
  logic [63:0]  den;
  logic [63:0]  rem;
  logic [6:0]   cnt;
  logic         busy;
  logic [64:0]  shifted;
  logic         take;

  // Shift in one numerator bit and try the subtraction
  always_comb begin
    shifted = {rem, num[127]};
    take    = shifted >= {1'b0, den};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 7'd0;
        num  <= req.num;
        den  <= req.den;
        rem  <= '0;
        quot <= '0;
      end else if (busy) begin
        num  <= {num[126:0], 1'b0};
        rem  <= take ? 64'(shifted - {1'b0, den}) : shifted[63:0];
        quot <= {quot[126:0], take};
        cnt  <= cnt + 7'd1;
        if (cnt == 7'd127) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

[design/ivf_sqrt.sv]
// ----------------------------------------------------------------------------
// ivf_sqrt
// Digit-by-digit integer square root of a 64-bit value, one bit a cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module ivf_sqrt (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [63:0] x,
  output logic             done,
  output logic [31:0]      root
);
  logic [63:0] val;
  logic [33:0] rem;
  logic [5:0]  cnt;
  logic        busy;
  logic [33:0] trial;
  logic [33:0] rem_sh;

  // Bring down two bits and test 4*root+1
  always_comb begin
    rem_sh = {rem[31:0], val[63:62]};
    trial  = {root, 2'b01};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        val  <= x;
        rem  <= '0;
        root <= '0;
        cnt  <= '0;
      end else if (busy) begin
        val <= {val[61:0], 2'b00};
        if (rem_sh >= trial) begin
          rem  <= rem_sh - trial;
          root <= {root[30:0], 1'b1};
        end else begin
          rem  <= rem_sh;
          root <= {root[30:0], 1'b0};
        end
        cnt <= cnt + 6'd1;
        if (cnt == 6'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

[design/inverse_variance_fusion.sv]
// ----------------------------------------------------------------------------
// inverse_variance_fusion
// Inverse-variance weighted fusion of a run of Gaussian estimates.
// ----------------------------------------------------------------------------
// Estimates arrive on in_ch (valid/ready). Flagged items are skipped; usable
// ones add weight 2^64/sigma^2 and mean*weight/2^32 to saturating sums. The item
// marked last_item closes the run: one result leaves on out_ch with fused
// mean, fused sigma, the used count and a status, and the sums clear.
// A skipped or zero-sigma item needs no division; a usable item holds in_ch
// through its weight division on the shared 128-step divider (one quotient
// bit a cycle). A closing item with status OK adds two divisions and a 32-step
// square root. One item is in work at a time; in_ch.ready is low meanwhile.
// The result is held in an output register until out_ch.ready; while it
// waits no new request is taken. Reset clears the sums and drops any result.
// ----------------------------------------------------------------------------
`default_nettype none
module inverse_variance_fusion #(
  parameter int MAX_ITEMS = 256
) (
  input wire logic  clk,
  input wire logic  rst,
  ivf_in_if.sink    in_ch,
  ivf_out_if.source out_ch
);
  localparam int CW = $clog2(MAX_ITEMS + 1);

  ivf_pkg::state_t state, state_next;

  logic [63:0]  weight_sum;
  logic signed [63:0] weighted_mean_sum;
  logic [CW-1:0] count_used;
  logic         zero_sigma_seen;
  logic         overflow_seen;

  logic [31:0]  mag;       // |mean|
  logic         neg;
  logic         last;
  logic [63:0]  acc;       // scratch: sigma^2, weight, product
  logic [63:0]  prod_lo;

  ivf_pkg::div_req_t dreq;
  logic         dstart, ddone;
  logic [127:0] dquot;
  logic         sstart, sdone;
  logic [31:0]  sroot;

  ivf_div u_div (.clk, .rst, .start(dstart), .req(dreq), .done(ddone), .quot(dquot));
  ivf_sqrt u_sqrt (.clk, .rst, .start(sstart), .x(dquot[63:0]), .done(sdone), .root(sroot));

  logic [1:0]  status_c;
  logic [63:0] smag;
  logic [64:0] wsum_add;
  logic signed [64:0] msum_add;
  logic        skip;

  always_comb begin
    skip = in_ch.invalid_flag | in_ch.unreliable_flag;
    smag = weighted_mean_sum[63] ? 64'(-weighted_mean_sum) : 64'(weighted_mean_sum);
    if (count_used == '0)        status_c = ivf_pkg::STATUS_EMPTY;
    else if (zero_sigma_seen)    status_c = ivf_pkg::STATUS_ZERO_SIG;
    else if (overflow_seen || weight_sum == '0) status_c = ivf_pkg::STATUS_OVERFLOW;
    else                         status_c = ivf_pkg::STATUS_OK;
    wsum_add = {1'b0, weight_sum} + {1'b0, acc};
    msum_add = neg ? 65'(weighted_mean_sum) - 65'(signed'({1'b0, acc}))
                   : 65'(weighted_mean_sum) + 65'(signed'({1'b0, acc}));
  end

  // Next state and unit starts
  always_comb begin
    state_next = state;
    dstart = 1'b0;
    sstart = 1'b0;
    dreq.num = {64'd1, 64'd0};
    dreq.den = acc;
    unique case (state)
      ivf_pkg::ST_IDLE: if (in_ch.valid) begin
        if (!skip && count_used < CW'(MAX_ITEMS) && in_ch.est_sigma != '0)
          state_next = ivf_pkg::ST_SQUARE;
        else if (in_ch.last_item) state_next = ivf_pkg::ST_MDIV;
      end
      ivf_pkg::ST_SQUARE: begin
        dstart = 1'b1;
        state_next = ivf_pkg::ST_WDIV;
      end
      ivf_pkg::ST_WDIV: if (ddone) state_next = ivf_pkg::ST_WSUM;
      ivf_pkg::ST_WSUM:  state_next = ivf_pkg::ST_MULLO;
      ivf_pkg::ST_MULLO: state_next = ivf_pkg::ST_MULHI;
      ivf_pkg::ST_MULHI: state_next = ivf_pkg::ST_MSUM;
      ivf_pkg::ST_MSUM:  state_next = last ? ivf_pkg::ST_MDIV : ivf_pkg::ST_IDLE;
      ivf_pkg::ST_MDIV: begin
        if (status_c != ivf_pkg::STATUS_OK) state_next = ivf_pkg::ST_OUT;
        else begin
          dstart = 1'b1;
          dreq.num = {32'd0, smag, 32'd0};
          dreq.den = weight_sum;
          state_next = ivf_pkg::ST_SDIV;
        end
      end
      ivf_pkg::ST_SDIV: if (ddone) begin
        dstart = 1'b1;
        dreq.den = weight_sum;
        state_next = ivf_pkg::ST_SQRT;
      end
      ivf_pkg::ST_SQRT: begin
        if (ddone && dquot[127:64] == '0) sstart = 1'b1;
        if (ddone && dquot[127:64] != '0) state_next = ivf_pkg::ST_OUT;
        if (sdone) state_next = ivf_pkg::ST_OUT;
      end
      ivf_pkg::ST_OUT: if (!out_ch.valid) state_next = ivf_pkg::ST_IDLE;
      default: state_next = ivf_pkg::ST_IDLE;
    endcase
  end

  assign in_ch.ready = (state == ivf_pkg::ST_IDLE) && !out_ch.valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ivf_pkg::ST_IDLE;
      weight_sum <= '0;
      weighted_mean_sum <= '0;
      count_used <= '0;
      zero_sigma_seen <= 1'b0;
      overflow_seen <= 1'b0;
      out_ch.valid <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) out_ch.valid <= 1'b0;
      if (state != ivf_pkg::ST_IDLE || !out_ch.valid) state <= state_next;
      unique case (state)
        ivf_pkg::ST_IDLE: if (in_ch.valid && in_ch.ready) begin
          // capture the request: square sigma, keep |mean| and its sign
          last <= in_ch.last_item;
          neg  <= in_ch.est_mean[31];
          mag  <= in_ch.est_mean[31] ? 32'(-in_ch.est_mean) : 32'(in_ch.est_mean);
          acc  <= 64'(in_ch.est_sigma) * 64'(in_ch.est_sigma);
          if (!skip && count_used < CW'(MAX_ITEMS)) begin
            count_used <= count_used + CW'(1);
            if (in_ch.est_sigma == '0) zero_sigma_seen <= 1'b1;
          end
        end
        ivf_pkg::ST_WDIV: if (ddone) begin
          if (dquot[127:64] != '0) begin
            acc <= '1;
            overflow_seen <= 1'b1;
          end else acc <= dquot[63:0];
        end
        ivf_pkg::ST_WSUM: begin
          if (wsum_add[64]) begin
            weight_sum <= '1;
            overflow_seen <= 1'b1;
          end else weight_sum <= wsum_add[63:0];
          prod_lo <= 64'(acc[31:0]) * 64'(mag);
        end
        ivf_pkg::ST_MULLO: acc <= 64'(acc[63:32]) * 64'(mag);
        ivf_pkg::ST_MULHI: acc <= acc + 64'(prod_lo[63:32]);
        ivf_pkg::ST_MSUM: begin
          if (msum_add[64] != msum_add[63]) begin
            weighted_mean_sum <= neg ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
            overflow_seen <= 1'b1;
          end else weighted_mean_sum <= msum_add[63:0];
        end
        ivf_pkg::ST_MDIV: begin
          out_ch.fused_mean  <= '0;
          out_ch.fused_sigma <= '0;
          out_ch.used_count  <= 9'(count_used);
          out_ch.status      <= status_c;
        end
        ivf_pkg::ST_SDIV: if (ddone) begin
          if (weighted_mean_sum[63]) begin
            if (dquot > 128'h8000_0000)
              out_ch.fused_mean <= 32'sh8000_0000;
            else out_ch.fused_mean <= 32'(-dquot[31:0]);
          end else begin
            if (dquot[127:31] != '0) out_ch.fused_mean <= 32'sh7FFF_FFFF;
            else out_ch.fused_mean <= dquot[31:0];
          end
        end
        ivf_pkg::ST_SQRT: begin
          if (ddone && dquot[127:64] != '0) out_ch.fused_sigma <= '1;
          if (sdone) out_ch.fused_sigma <= sroot;
        end
        ivf_pkg::ST_OUT: if (!out_ch.valid) begin
          out_ch.valid <= 1'b1;
          weight_sum <= '0;
          weighted_mean_sum <= '0;
          count_used <= '0;
          zero_sigma_seen <= 1'b0;
          overflow_seen <= 1'b0;
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire
